/* design/cdd_pkg.sv */
package cdd_pkg;

	localparam int CDD_QUEUE_DEPTH = 4;

	localparam logic [15:0] WORD_BYTES = 16'd4;
	localparam logic [1:0]  PAD_MASK   = 2'd3;

	typedef enum logic [1:0] {
		KIND_HEADER  = 2'd0,
		KIND_PAYLOAD = 2'd1,
		KIND_ERROR   = 2'd2
	} cdd_kind_t;

	typedef enum logic [1:0] {
		ERR_MAGIC   = 2'd0,
		ERR_LENGTH  = 2'd1,
		ERR_PARTIAL = 2'd2
	} cdd_err_t;

	typedef enum logic [1:0] {
		PH_IDLE    = 2'd0,
		PH_HEADER  = 2'd1,
		PH_PAYLOAD = 2'd2
	} cdd_phase_t;

	typedef struct packed {
		cdd_kind_t   kind;
		logic [15:0] cmd;
		logic [15:0] plen;
		logic [31:0] word;
		logic [2:0]  vb;
		logic        cmd_end;
		cdd_err_t    err;
	} cdd_result_t;

endpackage

/* design/cdd_front.sv */
module cdd_front import cdd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [31:0] cfg_wdata,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [31:0] data_word,
	input  logic        is_first,
	input  logic [15:0] datagram_length,
	input  logic        queue_full,
	output logic        push,
	output cdd_result_t push_data
);

	logic [31:0] magic_q;
	cdd_phase_t  phase_q, phase_d;
	logic [15:0] dbl_q, dbl_d;
	logic [15:0] pbl_q, pbl_d;

	logic        accept;
	logic        has_result;
	logic [15:0] dlen_rem;
	logic [15:0] dbl_dec;
	logic [15:0] plen;
	logic [2:0]  vb;
	logic        pay_end;

	assign in_stall = queue_full;
	assign accept   = in_valid && !in_stall;
	assign push     = accept && has_result;

	assign dlen_rem = datagram_length - WORD_BYTES;
	assign dbl_dec  = (dbl_q >= WORD_BYTES) ? dbl_q - WORD_BYTES : '0;
	assign plen     = data_word[31:16];
	assign vb       = (pbl_q < WORD_BYTES) ? pbl_q[2:0] : WORD_BYTES[2:0];
	assign pay_end  = (pbl_q <= WORD_BYTES);

	// next state
	always_comb begin
		phase_d = phase_q;
		dbl_d   = dbl_q;
		pbl_d   = pbl_q;
		if (is_first) begin
			phase_d = PH_IDLE;
			dbl_d   = '0;
			pbl_d   = '0;
			if (!(datagram_length < WORD_BYTES || data_word != magic_q) &&
			    (dlen_rem[1:0] & PAD_MASK) == 2'd0) begin
				dbl_d   = dlen_rem;
				phase_d = (dlen_rem != '0) ? PH_HEADER : PH_IDLE;
			end
		end else begin
			case (phase_q)
				PH_HEADER: begin
					if (dbl_dec < plen) begin
						phase_d = PH_IDLE;
						dbl_d   = '0;
						pbl_d   = '0;
					end else if (plen == '0) begin
						dbl_d   = dbl_dec;
						phase_d = (dbl_dec != '0) ? PH_HEADER : PH_IDLE;
					end else begin
						dbl_d   = dbl_dec;
						pbl_d   = plen;
						phase_d = PH_PAYLOAD;
					end
				end
				PH_PAYLOAD: begin
					dbl_d = dbl_dec;
					pbl_d = pbl_q - {13'd0, vb};
					if (pay_end)
						phase_d = (dbl_dec != '0) ? PH_HEADER : PH_IDLE;
				end
				default: begin
				end
			endcase
		end
	end

	// result classification
	always_comb begin
		has_result = 1'b0;
		push_data  = '{kind: KIND_HEADER, cmd: '0, plen: '0, word: '0, vb: '0,
		               cmd_end: 1'b0, err: ERR_MAGIC};
		if (is_first) begin
			if (datagram_length < WORD_BYTES || data_word != magic_q) begin
				has_result     = 1'b1;
				push_data.kind = KIND_ERROR;
				push_data.err  = ERR_MAGIC;
			end else if ((dlen_rem[1:0] & PAD_MASK) != 2'd0) begin
				has_result     = 1'b1;
				push_data.kind = KIND_ERROR;
				push_data.err  = ERR_LENGTH;
			end
		end else begin
			case (phase_q)
				PH_HEADER: begin
					has_result = 1'b1;
					if (dbl_dec < plen) begin
						push_data.kind = KIND_ERROR;
						push_data.err  = ERR_PARTIAL;
					end else begin
						push_data.kind    = KIND_HEADER;
						push_data.cmd     = data_word[15:0];
						push_data.plen    = plen;
						push_data.cmd_end = (plen == '0);
					end
				end
				PH_PAYLOAD: begin
					has_result        = 1'b1;
					push_data.kind    = KIND_PAYLOAD;
					push_data.word    = data_word;
					push_data.vb      = vb;
					push_data.cmd_end = pay_end;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			magic_q <= '0;
			phase_q <= PH_IDLE;
			dbl_q   <= '0;
			pbl_q   <= '0;
		end else begin
			if (cfg_we)
				magic_q <= cfg_wdata;
			if (accept) begin
				phase_q <= phase_d;
				dbl_q   <= dbl_d;
				pbl_q   <= pbl_d;
			end
		end
	end

	// inside a payload there is always something left to emit
	a_pay_left: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_PAYLOAD |-> pbl_q != '0)
		else $error("payload phase with no bytes left");

	// an error always ends the datagram
	a_err_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(push && push_data.kind == KIND_ERROR) |=> phase_q == PH_IDLE)
		else $error("phase not idle after error");

endmodule

/* design/cdd_queue.sv */
module cdd_queue import cdd_pkg::*; #(
	parameter int DEPTH = CDD_QUEUE_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	input  cdd_result_t push_data,
	output logic        full,
	input  logic        pop,
	output logic        not_empty,
	output cdd_result_t pop_data
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	cdd_result_t        mem_q [DEPTH];
	logic [PTR_W-1:0]   wptr_q, rptr_q;
	logic [CNT_W-1:0]   count_q;

	assign full      = (count_q == CNT_W'(DEPTH));
	assign not_empty = (count_q != '0);
	assign pop_data  = mem_q[rptr_q];

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wptr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (push)
				wptr_q <= (wptr_q == PTR_W'(DEPTH - 1)) ? '0 : wptr_q + 1'b1;
			if (pop)
				rptr_q <= (rptr_q == PTR_W'(DEPTH - 1)) ? '0 : rptr_q + 1'b1;
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> !push)
		else $error("push into full queue");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		!not_empty |-> !pop)
		else $error("pop from empty queue");

endmodule

/* design/cdd_back.sv */
module cdd_back import cdd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        not_empty,
	input  cdd_result_t pop_data,
	output logic        pop,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  result_kind,
	output logic [15:0] command_code,
	output logic [15:0] payload_bytes,
	output logic [31:0] payload_word,
	output logic [2:0]  valid_bytes,
	output logic        command_end,
	output logic [1:0]  error_code
);

	logic        valid_q;
	cdd_result_t res_q;

	// refill the output register when it is empty or being taken
	assign pop = not_empty && (!valid_q || !out_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_q <= 1'b0;
		else if (pop)
			valid_q <= 1'b1;
		else if (!out_stall)
			valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (pop)
			res_q <= pop_data;
	end

	assign out_valid     = valid_q;
	assign result_kind   = res_q.kind;
	assign command_code  = res_q.cmd;
	assign payload_bytes = res_q.plen;
	assign payload_word  = res_q.word;
	assign valid_bytes   = res_q.vb;
	assign command_end   = res_q.cmd_end;
	assign error_code    = res_q.err;

endmodule

/* design/control_datagram_deframer.sv */
// channel  | handshake             | payload
// cfg      | cfg_we                | cfg_wdata (magic_word)
// in       | in_valid / in_stall   | data_word, is_first, datagram_length
// out      | out_valid / out_stall | result_kind .. error_code
//
// One word accepted per cycle unless in_stall; front decode is combinational.
// A result passes the queue write, then the output register, before out_valid
// rises for it; a held out_stall or older queued results can delay the load.
// Reset clears the magic word, the decode state and the queue.
// With out_stall held, the queue (QUEUE_DEPTH entries) fills and in_stall rises.
module control_datagram_deframer import cdd_pkg::*; #(
	parameter int QUEUE_DEPTH = CDD_QUEUE_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [31:0] cfg_wdata,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [31:0] data_word,
	input  logic        is_first,
	input  logic [15:0] datagram_length,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  result_kind,
	output logic [15:0] command_code,
	output logic [15:0] payload_bytes,
	output logic [31:0] payload_word,
	output logic [2:0]  valid_bytes,
	output logic        command_end,
	output logic [1:0]  error_code
);

	logic        push, pop, full, not_empty;
	cdd_result_t push_data, pop_data;

	cdd_front u_front (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_we          (cfg_we),
		.cfg_wdata       (cfg_wdata),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.data_word       (data_word),
		.is_first        (is_first),
		.datagram_length (datagram_length),
		.queue_full      (full),
		.push            (push),
		.push_data       (push_data)
	);

	cdd_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (full),
		.pop       (pop),
		.not_empty (not_empty),
		.pop_data  (pop_data)
	);

	cdd_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.not_empty     (not_empty),
		.pop_data      (pop_data),
		.pop           (pop),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.result_kind   (result_kind),
		.command_code  (command_code),
		.payload_bytes (payload_bytes),
		.payload_word  (payload_word),
		.valid_bytes   (valid_bytes),
		.command_end   (command_end),
		.error_code    (error_code)
	);

endmodule

/* verif/tb_top.sv */
module tb_top import cdd_pkg::*; ();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned WATCHDOG_LIMIT = 2000;
	localparam int unsigned DRAIN_CYCLES   = 8;
	localparam int unsigned MAX_REPORTS    = 10;

	logic        clk;
	logic        arst_n          = 1'b0;
	logic        cfg_we          = 1'b0;
	logic [31:0] cfg_wdata       = '0;
	logic        in_valid        = 1'b0;
	logic        in_stall;
	logic [31:0] data_word       = '0;
	logic        is_first        = 1'b0;
	logic [15:0] datagram_length = '0;
	logic        out_valid;
	logic        out_stall       = 1'b0;
	logic [1:0]  result_kind;
	logic [15:0] command_code;
	logic [15:0] payload_bytes;
	logic [31:0] payload_word;
	logic [2:0]  valid_bytes;
	logic        command_end;
	logic [1:0]  error_code;

	// predictor state, mirrors the deframer
	logic [31:0] pred_magic   = '0;
	cdd_phase_t  pred_phase   = PH_IDLE;
	logic [15:0] pred_dg_left = '0;
	logic [15:0] pred_pl_left = '0;

	cdd_result_t pending_results[$];
	logic [31:0] frame_words[$];

	int unsigned src_idle_pct   = 23;
	int unsigned sink_idle_pct  = 86;
	int unsigned mismatch_count = 0;
	int unsigned stuck_cycles   = 0;
	int unsigned decoded_words  = 0;

	control_datagram_deframer dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_we          (cfg_we),
		.cfg_wdata       (cfg_wdata),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.data_word       (data_word),
		.is_first        (is_first),
		.datagram_length (datagram_length),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.result_kind     (result_kind),
		.command_code    (command_code),
		.payload_bytes   (payload_bytes),
		.payload_word    (payload_word),
		.valid_bytes     (valid_bytes),
		.command_end     (command_end),
		.error_code      (error_code)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// returns 1 when the word was consumed rather than ignored
	function automatic bit deframe_word(input logic [31:0] w, input logic first,
			input logic [15:0] len);
		cdd_result_t r;
		logic [15:0] rest;
		logic [15:0] hdr_len;
		r = '0;
		if (first) begin
			pred_phase = PH_IDLE;
			pred_dg_left = '0;
			pred_pl_left = '0;
			if (len < WORD_BYTES || w != pred_magic) begin
				r.kind = KIND_ERROR;
				r.err = ERR_MAGIC;
				pending_results.push_back(r);
			end else begin
				rest = len - WORD_BYTES;
				if ((rest[1:0] & PAD_MASK) != 2'd0) begin
					r.kind = KIND_ERROR;
					r.err = ERR_LENGTH;
					pending_results.push_back(r);
				end else begin
					pred_dg_left = rest;
					pred_phase = (rest != 0) ? PH_HEADER : PH_IDLE;
				end
			end
			return 1'b1;
		end
		case (pred_phase)
			PH_HEADER: begin
				hdr_len = w[31:16];
				pred_dg_left = (pred_dg_left >= WORD_BYTES) ? pred_dg_left - WORD_BYTES : '0;
				if (pred_dg_left < hdr_len) begin
					// header announces more payload than the datagram holds
					pred_phase = PH_IDLE;
					pred_dg_left = '0;
					pred_pl_left = '0;
					r.kind = KIND_ERROR;
					r.err = ERR_PARTIAL;
				end else if (hdr_len == 0) begin
					pred_phase = (pred_dg_left != 0) ? PH_HEADER : PH_IDLE;
					r.kind = KIND_HEADER;
					r.cmd = w[15:0];
					r.cmd_end = 1'b1;
				end else begin
					pred_phase = PH_PAYLOAD;
					pred_pl_left = hdr_len;
					r.kind = KIND_HEADER;
					r.cmd = w[15:0];
					r.plen = hdr_len;
				end
				pending_results.push_back(r);
				return 1'b1;
			end
			PH_PAYLOAD: begin
				r.kind = KIND_PAYLOAD;
				r.word = w;
				r.vb = (pred_pl_left < WORD_BYTES) ? pred_pl_left[2:0] : WORD_BYTES[2:0];
				r.cmd_end = (pred_pl_left <= WORD_BYTES);
				pred_pl_left = pred_pl_left - {13'd0, r.vb};
				pred_dg_left = (pred_dg_left >= WORD_BYTES) ? pred_dg_left - WORD_BYTES : '0;
				if (r.cmd_end)
					pred_phase = (pred_dg_left != 0) ? PH_HEADER : PH_IDLE;
				pending_results.push_back(r);
				return 1'b1;
			end
			default: return 1'b0;
		endcase
	endfunction

	// called at a rising edge; returns at the edge that accepts the transaction
	task automatic send_word(input logic [31:0] w, input logic first, input logic [15:0] len);
		while ($urandom_range(99) < src_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		data_word <= w;
		is_first <= first;
		datagram_length <= len;
		do @(posedge clk); while (in_stall);
		if (deframe_word(w, first, len))
			decoded_words++;
	endtask

	task automatic send_frame(input logic [15:0] dlen);
		foreach (frame_words[i])
			send_word(frame_words[i], i == 0, dlen);
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic set_magic(input logic [31:0] value);
		wait_drained();
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		pred_magic = value;
	endtask

	task automatic send_random_datagram();
		int unsigned flavor;
		int unsigned n_cmd;
		int unsigned plen;
		int unsigned total;
		int unsigned k;
		logic [15:0] dlen;
		flavor = $urandom_range(99);
		frame_words = {};
		frame_words.push_back(pred_magic);
		total = 4;
		n_cmd = $urandom_range(4);
		repeat (n_cmd) begin
			plen = ($urandom_range(9) == 0) ? $urandom_range(48, 13) : $urandom_range(12);
			frame_words.push_back({plen[15:0], 16'($urandom)});
			repeat ((plen + 3) / 4) frame_words.push_back($urandom);
			total += 4 + 4 * ((plen + 3) / 4);
		end
		dlen = total[15:0];
		if (flavor < 60) begin
			// well formed, nothing to change
		end else if (flavor < 66) begin
			if ($urandom_range(1))
				dlen = 16'($urandom_range(3));
			else
				frame_words[0] = pred_magic ^ (32'd1 << $urandom_range(31));
		end else if (flavor < 72) begin
			dlen = 16'(total + $urandom_range(3, 1));
		end else if (flavor < 80) begin
			// declared length too short: partial payload or trailing strays
			if (frame_words.size() > 1)
				dlen = 16'(total - 4 * $urandom_range(frame_words.size() - 1, 1));
		end else if (flavor < 88) begin
			// cut short, the next first word abandons it
			if (frame_words.size() > 1) begin
				k = $urandom_range(frame_words.size() - 1, 1);
				while (frame_words.size() > k)
					void'(frame_words.pop_back());
			end
		end else if (flavor < 94) begin
			repeat ($urandom_range(3, 1)) frame_words.push_back($urandom);
		end else begin
			// noise: random first word and length, random headers after it
			frame_words = {};
			frame_words.push_back($urandom_range(1) ? pred_magic : $urandom);
			dlen = 16'($urandom);
			if ($urandom_range(1))
				dlen[1:0] = 2'b00;
			repeat ($urandom_range(3)) frame_words.push_back($urandom);
		end
		send_frame(dlen);
	endtask

	task automatic run_random_datagrams(input int unsigned n_words);
		int unsigned target;
		target = decoded_words + n_words;
		while (decoded_words < target)
			send_random_datagram();
	endtask

	// reset magic of zero
	task automatic test_framing_edges();
		frame_words = {32'h0};
		send_frame(16'd4);
		send_frame(16'd3);
		send_frame(16'd0);
		frame_words = {32'h1, 32'h0000_0001};
		send_frame(16'd8);
		frame_words = {32'h0};
		send_frame(16'd9);
		frame_words = {32'h0, 32'h0000_FFFF, 32'h0005_0000, 32'hAABB_CCDD, 32'h1122_3344};
		send_frame(16'd20);
		send_word(32'hDEAD_BEEF, 1'b0, 16'd20);
		frame_words = {32'h0, 32'h0001_1234, 32'h5555_5555};
		send_frame(16'd8);
		frame_words = {32'h0, 32'h0008_0042, 32'h0102_0304};
		send_frame(16'd16);
	endtask

	task automatic test_magic_extremes();
		set_magic(32'hFFFF_FFFF);
		frame_words = {32'hFFFF_FFFF, 32'hFFFF_0000};
		send_frame(16'hFFFC);
		frame_words = {32'hFFFF_FFFF};
		send_frame(16'hFFFF);
		frame_words = {32'hFFFF_FFFF, 32'h0004_FFFF, 32'hFFFF_FFFF};
		send_frame(16'd12);
		frame_words = {32'hFFFF_FFFE};
		send_frame(16'd4);
	endtask

	task automatic test_random_slow_sink();
		src_idle_pct = 23;
		sink_idle_pct = 86;
		set_magic($urandom);
		run_random_datagrams(200);
		set_magic(32'h0);
		run_random_datagrams(170);
	endtask

	task automatic test_random_slow_source();
		src_idle_pct = 86;
		sink_idle_pct = 23;
		set_magic($urandom);
		run_random_datagrams(200);
		set_magic(32'hFFFF_FFFF);
		run_random_datagrams(170);
	endtask

	task automatic test_random_streaming();
		src_idle_pct = 0;
		sink_idle_pct = 0;
		set_magic($urandom);
		run_random_datagrams(370);
	endtask

	always @(posedge clk) begin : result_monitor
		cdd_result_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_results.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= MAX_REPORTS)
					$display("unexpected result transaction: kind %0d", result_kind);
			end else begin
				want = pending_results.pop_front();
				if (result_kind !== want.kind || command_code !== want.cmd ||
						payload_bytes !== want.plen || payload_word !== want.word ||
						valid_bytes !== want.vb || command_end !== want.cmd_end ||
						error_code !== want.err) begin
					mismatch_count++;
					if (mismatch_count <= MAX_REPORTS) begin
						$display("mismatch exp: kind %0d cmd %h plen %h word %h vb %0d end %b err %0d",
							want.kind, want.cmd, want.plen, want.word, want.vb,
							want.cmd_end, want.err);
						$display("         got: kind %0d cmd %h plen %h word %h vb %0d end %b err %0d",
							result_kind, command_code, payload_bytes, payload_word,
							valid_bytes, command_end, error_code);
					end
				end
			end
		end
		out_stall <= ($urandom_range(99) < sink_idle_pct);
	end

	// no transaction on either channel for too long means a hang
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
			stuck_cycles = 0;
		else
			stuck_cycles++;
		if (stuck_cycles >= WATCHDOG_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_framing_edges();
		test_magic_extremes();
		test_random_slow_sink();
		test_random_slow_source();
		test_random_streaming();
		wait_drained();
		if (mismatch_count == 0 && pending_results.size() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

/* sim.f */
design/cdd_pkg.sv
design/cdd_front.sv
design/cdd_queue.sv
design/cdd_back.sv
design/control_datagram_deframer.sv
verif/tb_top.sv
